/* rtl/mvt_pkg.sv */
// Shared types and constants for the 4x4 matrix-vector transform.
package mvt_pkg;

  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int DIM       = 4;
  localparam int NUM_REGS  = 8;
  localparam int REG_W     = 64;
  localparam int REG_IDX_W = $clog2(NUM_REGS);
  localparam int APB_AW    = REG_IDX_W + 3;

  typedef logic signed [DATA_W-1:0] coef_t;
  typedef coef_t [DIM-1:0]          vec_t;
  typedef vec_t  [DIM-1:0]          coef_mat_t;

  typedef struct packed {
    logic prod_en;
    logic res_en;
  } stage_ctl_t;

endpackage

/* rtl/mvt_regs.sv */
// APB register file holding the 4x4 coefficient matrix.
module mvt_regs #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mvt_pkg::APB_AW-1:0]      paddr,
  input  logic [mvt_pkg::REG_W-1:0]       pwdata,
  output logic [mvt_pkg::REG_W-1:0]       prdata,
  output logic                            pready,
  output mvt_pkg::coef_mat_t              coef_o
);
  import mvt_pkg::*;

  localparam logic [DATA_W-1:0] One = DATA_W'(1) << FRAC_BITS;

  logic [REG_W-1:0]     regs_q [NUM_REGS];
  logic                 wr_en;
  logic [REG_IDX_W-1:0] wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_idx = paddr[APB_AW-1:3];
  assign prdata = regs_q[wr_idx];

  for (genvar i = 0; i < NUM_REGS; i++) begin : g_reg
    localparam int Row  = i / 2;
    localparam int Pair = i % 2;
    // identity: ones on the diagonal only
    localparam logic [REG_W-1:0] RstVal = {
      (Row == 2 * Pair)     ? One : {DATA_W{1'b0}},
      (Row == 2 * Pair + 1) ? One : {DATA_W{1'b0}}
    };

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        regs_q[i] <= RstVal;
      end else if (wr_en && (wr_idx == REG_IDX_W'(i))) begin
        regs_q[i] <= pwdata;
      end
    end
  end

  for (genvar r = 0; r < DIM; r++) begin : g_row
    assign coef_o[r][0] = regs_q[2*r][REG_W-1:DATA_W];
    assign coef_o[r][1] = regs_q[2*r][DATA_W-1:0];
    assign coef_o[r][2] = regs_q[2*r+1][REG_W-1:DATA_W];
    assign coef_o[r][3] = regs_q[2*r+1][DATA_W-1:0];
  end

`ifndef SYNTHESIS
  a_write_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> regs_q[$past(wr_idx)] == $past(pwdata))
    else $error("register write not stored");
`endif

endmodule

/* rtl/mvt_dot.sv */
// One matrix row dotted with the input vector: product stage, then sum/round/saturate.
module mvt_dot #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  mvt_pkg::stage_ctl_t                 ctl_i,
  input  mvt_pkg::vec_t                       row_i,
  input  mvt_pkg::vec_t                       vec_i,
  output logic signed [mvt_pkg::DATA_W-1:0]   res_o,
  output logic                                sat_o
);
  import mvt_pkg::*;

  localparam logic signed [SUM_W-1:0]  RoundHalf = SUM_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [DATA_W-1:0] SatMax    = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SatMin    = {1'b1, {(DATA_W-1){1'b0}}};

  logic signed [PROD_W-1:0] prod_q [DIM];
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  rnd;
  logic signed [SUM_W-1:0]  shr;
  logic [SUM_W-DATA_W:0]    top_bits;
  logic                     fits;
  logic signed [DATA_W-1:0] res_d;
  logic signed [DATA_W-1:0] res_q;
  logic                     sat_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.prod_en) begin
      for (int c = 0; c < DIM; c++) begin
        prod_q[c] <= PROD_W'(row_i[c]) * PROD_W'(vec_i[c]);
      end
    end
  end

  always_comb begin
    sum = SUM_W'(prod_q[0]) + SUM_W'(prod_q[1]) + SUM_W'(prod_q[2]) + SUM_W'(prod_q[3]);
    rnd = sum + RoundHalf;
    shr = rnd >>> FRAC_BITS;
    // in range when everything from bit 31 up is a copy of the sign
    top_bits = shr[SUM_W-1:DATA_W-1];
    fits     = (&top_bits) || !(|top_bits);
    if (fits) begin
      res_d = shr[DATA_W-1:0];
    end else begin
      res_d = shr[SUM_W-1] ? SatMin : SatMax;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.res_en) begin
      res_q <= res_d;
      sat_q <= !fits;
    end
  end

  assign res_o = res_q;
  assign sat_o = sat_q;

endmodule

/* rtl/matrix_vector_transform_4x4.sv */
// Multiplies each signed fixed-point 4-vector by a programmable 4x4 matrix (top level).
//
// One vector is taken per clock: busy stays low, so every cycle with start high
// is a new beat. The result appears on the outputs after the input register,
// the registered 32x32 multipliers (sixteen of them) and the sum/round/saturate
// register, marked by done_o for exactly one cycle. The receiver cannot
// stall, so results must be taken as they come.
// Each output is the row dot product summed at full width, rounded to nearest
// (ties up) at FRAC_BITS fraction bits and saturated to 32 bits; overflow_o
// flags any clipped component. The matrix resets to identity and is written
// over APB, 64-bit registers at byte address 8*i; write it only while no
// vector is in flight.
module matrix_vector_transform_4x4 #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mvt_pkg::APB_AW-1:0]          paddr,
  input  logic [mvt_pkg::REG_W-1:0]           pwdata,
  output logic [mvt_pkg::REG_W-1:0]           prdata,
  output logic                                pready,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [mvt_pkg::DATA_W-1:0]   in_x_i,
  input  logic signed [mvt_pkg::DATA_W-1:0]   in_y_i,
  input  logic signed [mvt_pkg::DATA_W-1:0]   in_z_i,
  input  logic signed [mvt_pkg::DATA_W-1:0]   in_w_i,
  output logic                                done_o,
  output logic signed [mvt_pkg::DATA_W-1:0]   out_x_o,
  output logic signed [mvt_pkg::DATA_W-1:0]   out_y_o,
  output logic signed [mvt_pkg::DATA_W-1:0]   out_z_o,
  output logic signed [mvt_pkg::DATA_W-1:0]   out_w_o,
  output logic                                overflow_o
);
  import mvt_pkg::*;

  localparam logic signed [DATA_W-1:0] SatMax = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SatMin = {1'b1, {(DATA_W-1){1'b0}}};

  coef_mat_t  coef;
  vec_t       in_q;
  logic       accept;
  logic       in_vld_q;
  logic       prod_vld_q;
  logic       done_q;
  stage_ctl_t ctl;
  vec_t       res;
  logic [DIM-1:0] sat;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  mvt_regs #(
    .FRAC_BITS(FRAC_BITS)
  ) u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .coef_o (coef)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q[0] <= in_x_i;
      in_q[1] <= in_y_i;
      in_q[2] <= in_z_i;
      in_q[3] <= in_w_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      in_vld_q   <= accept;
      prod_vld_q <= in_vld_q;
      done_q     <= prod_vld_q;
    end
  end

  assign ctl.prod_en = in_vld_q;
  assign ctl.res_en  = prod_vld_q;

  for (genvar r = 0; r < DIM; r++) begin : g_dot
    mvt_dot #(
      .FRAC_BITS(FRAC_BITS)
    ) u_dot (
      .clk_i(clk_i),
      .ctl_i(ctl),
      .row_i(coef[r]),
      .vec_i(in_q),
      .res_o(res[r]),
      .sat_o(sat[r])
    );
  end

  assign done_o     = done_q;
  assign out_x_o    = res[0];
  assign out_y_o    = res[1];
  assign out_z_o    = res[2];
  assign out_w_o    = res[3];
  assign overflow_o = |sat;

`ifndef SYNTHESIS
  a_beat_completes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##3 done_o)
    else $error("accepted beat produced no result");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 3))
    else $error("result without an accepted beat");

  a_ovf_clipped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && overflow_o) |->
      (out_x_o == SatMax || out_x_o == SatMin || out_y_o == SatMax ||
       out_y_o == SatMin || out_z_o == SatMax || out_z_o == SatMin ||
       out_w_o == SatMax || out_w_o == SatMin))
    else $error("overflow flagged with no clipped component");
`endif

endmodule

/* dv/matrix_vector_transform_4x4_tb.sv */
// Self-checking testbench for the 4x4 fixed-point matrix-vector transform.
`timescale 1ns / 1ps

module matrix_vector_transform_4x4_tb;
  import mvt_pkg::*;

  localparam int FRAC_BITS      = 16;
  localparam int ADDR_W         = APB_AW;
  localparam int REG_BYTES      = 8;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_PRINTED    = 100;

  localparam coef_t Q_ONE = coef_t'(1 << FRAC_BITS);
  localparam coef_t Q_MAX = coef_t'(32'h7FFF_FFFF);
  localparam coef_t Q_MIN = coef_t'(32'h8000_0000);

  localparam logic signed [SUM_W-1:0] ROUND_HALF = 1 <<< (FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] SAT_HI     = 2147483647;
  localparam logic signed [SUM_W-1:0] SAT_LO     = -SAT_HI - 1;

  typedef enum {
    MAT_IDENTITY,
    MAT_RANDOM,
    MAT_ZERO,
    MAT_POS_MAX,
    MAT_NEG_MAX,
    MAT_MINUS_LSB
  } mat_kind_e;

  typedef struct packed {
    vec_t comp;
    logic ovf;
  } xform_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [REG_W-1:0]  pwdata;
  logic [REG_W-1:0]  prdata;
  logic              pready;
  logic              start;
  logic              busy;
  coef_t             in_x_i;
  coef_t             in_y_i;
  coef_t             in_z_i;
  coef_t             in_w_i;
  logic              done_o;
  coef_t             out_x_o;
  coef_t             out_y_o;
  coef_t             out_z_o;
  coef_t             out_w_o;
  logic              overflow_o;

  logic [REG_W-1:0] coef_regs [NUM_REGS];
  xform_t           pending_results [$];
  int               mismatch_count;
  int               stall_cycles;
  string            comp_names [DIM] = '{"out_x", "out_y", "out_z", "out_w"};

  matrix_vector_transform_4x4 #(
    .FRAC_BITS(FRAC_BITS)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .start     (start),
    .busy      (busy),
    .in_x_i    (in_x_i),
    .in_y_i    (in_y_i),
    .in_z_i    (in_z_i),
    .in_w_i    (in_w_i),
    .done_o    (done_o),
    .out_x_o   (out_x_o),
    .out_y_o   (out_y_o),
    .out_z_o   (out_z_o),
    .out_w_o   (out_w_o),
    .overflow_o(overflow_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Matrix times vector: exact row sums, round half up, clip to 32 bits.
  function automatic xform_t transform(vec_t v);
    xform_t                   res;
    logic [REG_W-1:0]         word;
    coef_t                    c;
    logic signed [SUM_W-1:0]  prod;
    logic signed [SUM_W-1:0]  acc;
    logic signed [SUM_W-1:0]  rounded;
    res.ovf = 1'b0;
    for (int r = 0; r < DIM; r++) begin
      acc = '0;
      for (int k = 0; k < DIM; k++) begin
        word = coef_regs[2 * r + k / 2];
        c    = (k % 2 == 1) ? coef_t'(word[31:0]) : coef_t'(word[63:32]);
        prod = c * $signed(v[k]);
        acc  = acc + prod;
      end
      acc     = acc + ROUND_HALF;
      rounded = acc >>> FRAC_BITS;
      if (rounded > SAT_HI) begin
        res.comp[r] = Q_MAX;
        res.ovf     = 1'b1;
      end else if (rounded < SAT_LO) begin
        res.comp[r] = Q_MIN;
        res.ovf     = 1'b1;
      end else begin
        res.comp[r] = rounded[DATA_W-1:0];
      end
    end
    return res;
  endfunction

  // Mix of full-range, moderate, unit-range, tiny and corner values.
  function automatic coef_t rand_q();
    case ($urandom_range(0, 7)) inside
      [0:2]: return coef_t'($urandom);
      [3:4]: return coef_t'($urandom_range(0, 16 << FRAC_BITS)) - coef_t'(8 << FRAC_BITS);
      5:     return coef_t'($urandom_range(0, 2 << FRAC_BITS)) - Q_ONE;
      6: begin
        case ($urandom_range(0, 5))
          0:       return Q_MAX;
          1:       return Q_MIN;
          2:       return Q_ONE;
          3:       return -Q_ONE;
          4:       return coef_t'(-1);
          default: return '0;
        endcase
      end
      default: return coef_t'($urandom_range(0, 255)) - coef_t'(128);
    endcase
  endfunction

  function automatic vec_t mk_vec(coef_t x, coef_t y, coef_t z, coef_t w);
    vec_t v;
    v[0] = x;
    v[1] = y;
    v[2] = z;
    v[3] = w;
    return v;
  endfunction

  function automatic vec_t rand_vec();
    return mk_vec(rand_q(), rand_q(), rand_q(), rand_q());
  endfunction

  function automatic coef_mat_t build_matrix(mat_kind_e kind);
    coef_mat_t m;
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        case (kind)
          MAT_IDENTITY:  m[r][c] = (r == c) ? Q_ONE : '0;
          MAT_RANDOM:    m[r][c] = rand_q();
          MAT_POS_MAX:   m[r][c] = Q_MAX;
          MAT_NEG_MAX:   m[r][c] = Q_MIN;
          MAT_MINUS_LSB: m[r][c] = coef_t'(-1);
          default:       m[r][c] = '0;
        endcase
      end
    end
    return m;
  endfunction

  // Register idx holds two adjacent coefficients of one row, lower column on top.
  function automatic logic [REG_W-1:0] pack_pair(coef_mat_t m, int idx);
    return {m[idx / 2][(idx % 2) * 2], m[idx / 2][(idx % 2) * 2 + 1]};
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task automatic reg_write(int idx, logic [REG_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx * REG_BYTES);
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    coef_regs[idx] = value;
  endtask

  task automatic reg_read(int idx, output logic [REG_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'(idx * REG_BYTES);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    value = prdata;
  endtask

  task automatic check_registers();
    logic [REG_W-1:0] word;
    for (int idx = 0; idx < NUM_REGS; idx++) begin
      reg_read(idx, word);
      if (word !== coef_regs[idx])
        report_mismatch($sformatf("reg %0d readback: expected %h, got %h",
                                  idx, coef_regs[idx], word));
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_matrix(coef_mat_t m);
    for (int idx = 0; idx < NUM_REGS; idx++) reg_write(idx, pack_pair(m, idx));
    check_registers();
  endtask

  task automatic send_vec(vec_t v);
    @(negedge clk_i);
    start  <= 1'b1;
    in_x_i <= v[0];
    in_y_i <= v[1];
    in_z_i <= v[2];
    in_w_i <= v[3];
    do @(posedge clk_i); while (busy);
  endtask

  // Junk on the data ports while start is low must be ignored.
  task automatic idle_cycle();
    @(negedge clk_i);
    start  <= 1'b0;
    in_x_i <= coef_t'($urandom);
    in_y_i <= coef_t'($urandom);
    in_z_i <= coef_t'($urandom);
    in_w_i <= coef_t'($urandom);
  endtask

  task automatic pause_until_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic stream_vectors(int count, int idle_pct);
    for (int i = 0; i < count; i++) begin
      while ($urandom_range(0, 99) < idle_pct) idle_cycle();
      if ($urandom_range(0, 249) == 0) pause_until_drained();
      send_vec(rand_vec());
    end
    pause_until_drained();
  endtask

  task automatic test_reset_state();
    check_registers();
    send_vec(mk_vec('0, '0, '0, '0));
    send_vec(mk_vec(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
    send_vec(mk_vec(Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    send_vec(mk_vec(Q_MAX, Q_MIN, coef_t'(1), coef_t'(-1)));
    send_vec(mk_vec(Q_ONE, -Q_ONE, coef_t'(32'h5555_5555), coef_t'(32'hAAAA_AAAA)));
    pause_until_drained();
  endtask

  // Half-LSB sums of both signs; ties must go upward.
  task automatic test_rounding_ties();
    coef_mat_t m;
    m       = build_matrix(MAT_ZERO);
    m[0][0] = coef_t'(32'h0000_8000);
    m[1][0] = coef_t'(-32'sh8000);
    m[2][0] = coef_t'(32'h0000_4000);
    m[3][1] = coef_t'(-1);
    load_matrix(m);
    send_vec(mk_vec(coef_t'(1), '0, '0, '0));
    send_vec(mk_vec(coef_t'(-1), '0, '0, '0));
    send_vec(mk_vec(coef_t'(3), coef_t'(32'h0000_8000), '0, '0));
    send_vec(mk_vec(coef_t'(-3), coef_t'(-32'sh8000), '0, '0));
    send_vec(mk_vec(coef_t'(2), coef_t'(32'h0001_8000), '0, '0));
    send_vec(mk_vec(Q_MAX, Q_MIN, '0, '0));
    pause_until_drained();
  endtask

  task automatic test_saturation();
    load_matrix(build_matrix(MAT_POS_MAX));
    send_vec(mk_vec(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
    send_vec(mk_vec(Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    send_vec(mk_vec(Q_MAX, Q_MIN, Q_MAX, Q_MIN));
    send_vec(mk_vec(Q_ONE, Q_ONE, Q_ONE, Q_ONE));
    pause_until_drained();
    load_matrix(build_matrix(MAT_NEG_MAX));
    send_vec(mk_vec(Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    send_vec(mk_vec(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
    pause_until_drained();
  endtask

  // M * B, one column of B per beat, back to back; then hold off until all are back.
  task automatic test_matrix_product();
    coef_mat_t b;
    load_matrix(build_matrix(MAT_RANDOM));
    b = build_matrix(MAT_RANDOM);
    for (int c = 0; c < DIM; c++) send_vec(mk_vec(b[0][c], b[1][c], b[2][c], b[3][c]));
    pause_until_drained();
  endtask

  task automatic test_back_to_back();
    load_matrix(build_matrix(MAT_RANDOM));
    stream_vectors(300, 0);
    load_matrix(build_matrix(MAT_NEG_MAX));
    stream_vectors(100, 0);
  endtask

  task automatic test_sender_gaps();
    load_matrix(build_matrix(MAT_RANDOM));
    stream_vectors(300, 71);
    load_matrix(build_matrix(MAT_RANDOM));
    stream_vectors(100, 23);
  endtask

  task automatic test_extreme_matrices();
    load_matrix(build_matrix(MAT_POS_MAX));
    stream_vectors(100, 23);
    load_matrix(build_matrix(MAT_MINUS_LSB));
    stream_vectors(50, 23);
    load_matrix(build_matrix(MAT_ZERO));
    stream_vectors(50, 71);
    load_matrix(build_matrix(MAT_IDENTITY));
    stream_vectors(50, 0);
  endtask

  // Inputs and outputs are sampled here with their pre-edge values.
  always @(posedge clk_i) begin : result_check
    xform_t want;
    xform_t got;
    if (rst_ni) begin
      if (start && !busy) pending_results.push_back(transform({in_w_i, in_z_i, in_y_i, in_x_i}));
      if (done_o) begin
        got.comp[0] = out_x_o;
        got.comp[1] = out_y_o;
        got.comp[2] = out_z_o;
        got.comp[3] = out_w_o;
        got.ovf     = overflow_o;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing pending: %h", got));
        end else begin
          want = pending_results.pop_front();
          for (int i = 0; i < DIM; i++)
            if (got.comp[i] !== want.comp[i])
              report_mismatch($sformatf("%s: expected %h, got %h",
                                        comp_names[i], want.comp[i], got.comp[i]));
          if (got.ovf !== want.ovf)
            report_mismatch($sformatf("overflow: expected %b, got %b", want.ovf, got.ovf));
        end
      end
      if ((start && !busy) || done_o || (psel && penable && pready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("matrix_vector_transform_4x4 test failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    start          = 1'b0;
    in_x_i         = '0;
    in_y_i         = '0;
    in_z_i         = '0;
    in_w_i         = '0;
    mismatch_count = 0;
    stall_cycles   = 0;
    for (int idx = 0; idx < NUM_REGS; idx++)
      coef_regs[idx] = pack_pair(build_matrix(MAT_IDENTITY), idx);
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_rounding_ties();
    test_saturation();
    test_matrix_product();
    test_back_to_back();
    test_sender_gaps();
    test_extreme_matrices();

    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("matrix_vector_transform_4x4 test passed");
    end else begin
      $display("matrix_vector_transform_4x4 test failed");
    end
    $finish;
  end

endmodule
